### hw/rtl/lrbp_pkg.sv
// Shared types, codes and helpers for the link reconnect backoff policy.
package lrbp_pkg;

    // Event kinds
    localparam logic [2:0] REQ_TICK        = 3'd0;
    localparam logic [2:0] REQ_NET_CHANGE  = 3'd1;
    localparam logic [2:0] REQ_CONNECT_NOW = 3'd2;
    localparam logic [2:0] REQ_RESTART     = 3'd3;
    localparam logic [2:0] REQ_RESULT      = 3'd4;
    localparam logic [2:0] REQ_DROPPED     = 3'd5;
    localparam logic [2:0] REQ_SETTINGS    = 3'd6;

    // Actions
    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_CONNECT    = 2'd1;
    localparam logic [1:0] ACT_DISCONNECT = 2'd2;

    // Link state codes
    localparam logic [2:0] LS_OFF        = 3'd0;
    localparam logic [2:0] LS_NO_NETWORK = 3'd1;
    localparam logic [2:0] LS_CONNECTING = 3'd2;
    localparam logic [2:0] LS_WAITING    = 3'd3;
    localparam logic [2:0] LS_CONNECTED  = 3'd4;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_ENABLED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_CAP = 2'd2;

    localparam logic [31:0] MIN_RETRY_MS   = 32'd100;
    localparam logic [31:0] RESET_RETRY_MS = 32'd1000;
    localparam logic [31:0] RESET_CAP_MS   = 32'd60000;
    localparam logic [31:0] NEVER_MS       = 32'hFFFF_FFFF;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] now_ms;
        logic        event_flag;
    } event_t;

    typedef struct packed {
        logic        link_enabled;
        logic [31:0] eff_base;   // retry interval, already floored
        logic [31:0] cap_raw;
    } cfg_t;

    typedef struct packed {
        logic        is_connected;
        logic        is_awaiting;
        logic        network_up;
        logic        restart_pending;
        logic [31:0] backoff_interval;
        logic [31:0] next_attempt_time;
        logic [31:0] connect_time;
        logic [15:0] connects_total;
        logic [15:0] failures_total;
        logic [15:0] drops_total;
    } pol_state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  link_state;
        logic [31:0] next_attempt_in_ms;
        logic [31:0] connected_for_ms;
        logic [15:0] connect_count;
        logic [15:0] failure_count;
        logic [15:0] drop_count;
    } result_t;

    // rem = target - now; target counts as reached when now - target < 2^31
    function automatic logic rem_reached(input logic [31:0] rem);
        return (rem == 32'd0) || (rem[31] && (rem[30:0] != 31'd0));
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
        return (cnt == COUNT_MAX) ? cnt : cnt + 16'd1;
    endfunction

endpackage

### hw/rtl/lrbp_step.sv
// Next-state and status logic for one policy event.
module lrbp_step (
    input  lrbp_pkg::pol_state_t st,
    input  lrbp_pkg::cfg_t       cfg,
    input  lrbp_pkg::event_t     ev,
    output lrbp_pkg::pol_state_t st_next,
    output lrbp_pkg::result_t    res
);

    logic [31:0] eff_cap;
    logic [31:0] backoff_grown;
    logic [31:0] rem_old;
    logic [31:0] rem;
    logic [31:0] now_plus_backoff;
    logic [31:0] now_plus_base;
    logic        ct_fresh;
    logic [1:0]  act;
    lrbp_pkg::pol_state_t nx;

    assign eff_cap          = (cfg.cap_raw < cfg.eff_base) ? cfg.eff_base : cfg.cap_raw;
    assign backoff_grown    = (st.backoff_interval > {1'b0, eff_cap[31:1]}) ?
                              eff_cap : {st.backoff_interval[30:0], 1'b0};
    assign rem_old          = st.next_attempt_time - ev.now_ms;
    assign now_plus_backoff = ev.now_ms + st.backoff_interval;
    assign now_plus_base    = ev.now_ms + cfg.eff_base;

    // rem tracks next_attempt_time - now for the updated state, so the
    // status needs no second subtract after the schedule update
    always_comb begin
        nx       = st;
        act      = lrbp_pkg::ACT_NONE;
        rem      = rem_old;
        ct_fresh = 1'b0;
        unique case (ev.req_type)
            lrbp_pkg::REQ_TICK: begin
                if (st.is_connected || st.is_awaiting) begin
                    if (!(cfg.link_enabled && st.network_up && !st.restart_pending)) begin
                        nx.is_connected      = 1'b0;
                        nx.is_awaiting       = 1'b0;
                        nx.restart_pending   = 1'b0;
                        nx.backoff_interval  = cfg.eff_base;
                        nx.next_attempt_time = ev.now_ms;
                        rem                  = '0;
                        act                  = lrbp_pkg::ACT_DISCONNECT;
                    end
                end else begin
                    if (st.restart_pending) begin
                        nx.restart_pending   = 1'b0;
                        nx.backoff_interval  = cfg.eff_base;
                        nx.next_attempt_time = ev.now_ms;
                        rem                  = '0;
                    end
                    if (cfg.link_enabled && st.network_up &&
                        (st.restart_pending || lrbp_pkg::rem_reached(rem_old))) begin
                        nx.is_awaiting = 1'b1;
                        act            = lrbp_pkg::ACT_CONNECT;
                    end
                end
            end
            lrbp_pkg::REQ_NET_CHANGE: begin
                if (ev.event_flag != st.network_up) begin
                    nx.network_up = ev.event_flag;
                    if (ev.event_flag) begin
                        nx.backoff_interval  = cfg.eff_base;
                        nx.next_attempt_time = ev.now_ms;
                        rem                  = '0;
                    end
                end
            end
            lrbp_pkg::REQ_CONNECT_NOW: begin
                nx.backoff_interval  = cfg.eff_base;
                nx.next_attempt_time = ev.now_ms;
                rem                  = '0;
            end
            lrbp_pkg::REQ_RESTART: begin
                if (st.is_connected || st.is_awaiting) begin
                    nx.restart_pending = 1'b1;
                end else begin
                    nx.backoff_interval  = cfg.eff_base;
                    nx.next_attempt_time = ev.now_ms;
                    rem                  = '0;
                end
            end
            lrbp_pkg::REQ_RESULT: begin
                if (st.is_awaiting) begin
                    nx.is_awaiting = 1'b0;
                    if (ev.event_flag) begin
                        nx.is_connected     = 1'b1;
                        nx.connect_time     = ev.now_ms;
                        ct_fresh            = 1'b1;
                        nx.connects_total   = lrbp_pkg::sat_inc(st.connects_total);
                        nx.failures_total   = '0;
                        nx.backoff_interval = cfg.eff_base;
                    end else begin
                        nx.failures_total    = lrbp_pkg::sat_inc(st.failures_total);
                        nx.next_attempt_time = now_plus_backoff;
                        rem                  = st.backoff_interval;
                        nx.backoff_interval  = backoff_grown;
                    end
                end
            end
            lrbp_pkg::REQ_DROPPED: begin
                if (st.is_connected) begin
                    nx.is_connected      = 1'b0;
                    nx.drops_total       = lrbp_pkg::sat_inc(st.drops_total);
                    nx.backoff_interval  = cfg.eff_base;
                    nx.next_attempt_time = now_plus_base;
                    rem                  = cfg.eff_base;
                end
            end
            lrbp_pkg::REQ_SETTINGS: begin
                if (!st.is_connected && !st.is_awaiting) begin
                    nx.backoff_interval  = cfg.eff_base;
                    nx.next_attempt_time = ev.now_ms;
                    rem                  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res        = '0;
        res.action = act;
        priority if (nx.is_connected) begin
            res.link_state = lrbp_pkg::LS_CONNECTED;
        end else if (nx.is_awaiting) begin
            res.link_state = lrbp_pkg::LS_CONNECTING;
        end else if (!cfg.link_enabled) begin
            res.link_state = lrbp_pkg::LS_OFF;
        end else if (!nx.network_up) begin
            res.link_state = lrbp_pkg::LS_NO_NETWORK;
        end else begin
            res.link_state = lrbp_pkg::LS_WAITING;
        end

        priority if (nx.is_connected || !cfg.link_enabled || !nx.network_up) begin
            res.next_attempt_in_ms = lrbp_pkg::NEVER_MS;
        end else if (nx.is_awaiting || lrbp_pkg::rem_reached(rem)) begin
            res.next_attempt_in_ms = '0;
        end else begin
            res.next_attempt_in_ms = rem;
        end

        res.connected_for_ms = (nx.is_connected && !ct_fresh) ?
                               (ev.now_ms - st.connect_time) : 32'd0;
        res.connect_count    = nx.connects_total;
        res.failure_count    = nx.failures_total;
        res.drop_count       = nx.drops_total;
    end

    assign st_next = nx;

endmodule

### hw/rtl/link_reconnect_backoff_policy.sv
// Top level of the link reconnect backoff policy: beat registers, settings, policy state.
//
//  channel | dir | handshake             | contents
//  --------+-----+-----------------------+-------------------------------------------
//  s_      | in  | s_tvalid / s_tready   | one link event per beat
//  m_      | out | m_tvalid / m_tready   | one status result per event beat
//  cfg_    | in  | cfg_wr_en (no wait)   | settings write by register index
//
//  One beat per cycle sustained while m_ is not stalled; m_tvalid rises once an accepted
//  beat has passed the input register and then the result register. The policy state is
//  updated at the same edge as the result register, so the next event sees it at once.
//  aresetn is synchronous, active low; it clears valids and policy state, resets settings.
//  A stalled m_ side holds the result; the input register still takes one beat,
//  after which s_tready drops until the result is taken.
module link_reconnect_backoff_policy (
    input  logic                               aclk,
    input  logic                               aresetn,
    // event beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [39:0]                        s_tdata,   // [31:0] now_ms, [32] event_flag
    input  logic [2:0]                         s_tuser,   // [2:0] req_type
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] action, [4:2] link_state, [36:5] next_attempt_in_ms,
    // [68:37] connected_for_ms, [84:69] connect_count, [100:85] failure_count,
    // [116:101] drop_count
    output logic [119:0]                       m_tdata,
    // settings write port
    input  logic                               cfg_wr_en,
    input  logic [lrbp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data
);

    // beat registers
    logic                 in_valid_reg, in_valid_next;
    lrbp_pkg::event_t     in_reg;
    logic                 out_valid_reg, out_valid_next;
    lrbp_pkg::result_t    out_reg;

    // settings
    lrbp_pkg::cfg_t       cfg_reg;

    // policy state
    lrbp_pkg::pol_state_t st_reg;
    lrbp_pkg::pol_state_t st_next;
    lrbp_pkg::result_t    res;

    logic s_accept;
    logic out_ready;
    logic advance;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    lrbp_step u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .ev      (in_reg),
        .st_next (st_next),
        .res     (res)
    );

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                st_reg <= st_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg.req_type   <= s_tuser;
            in_reg.now_ms     <= s_tdata[31:0];
            in_reg.event_flag <= s_tdata[32];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    // settings: the retry interval is floored at write time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.link_enabled <= 1'b0;
            cfg_reg.eff_base     <= lrbp_pkg::RESET_RETRY_MS;
            cfg_reg.cap_raw      <= lrbp_pkg::RESET_CAP_MS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lrbp_pkg::REG_LINK_ENABLED: begin
                    cfg_reg.link_enabled <= cfg_data[0];
                end
                lrbp_pkg::REG_RETRY_INTERVAL: begin
                    cfg_reg.eff_base <= (cfg_data < lrbp_pkg::MIN_RETRY_MS) ?
                                        lrbp_pkg::MIN_RETRY_MS : cfg_data;
                end
                lrbp_pkg::REG_RETRY_CAP: begin
                    cfg_reg.cap_raw <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.drop_count,
                       out_reg.failure_count,
                       out_reg.connect_count,
                       out_reg.connected_for_ms,
                       out_reg.next_attempt_in_ms,
                       out_reg.link_state,
                       out_reg.action};

    // connected and awaiting an attempt result never hold together
    a_conn_await_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st_reg.is_connected && st_reg.is_awaiting))
        else $error("connected and awaiting both set");

    // only a tick may ask for an action
    a_action_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (res.action != lrbp_pkg::ACT_NONE)) |->
        (in_reg.req_type == lrbp_pkg::REQ_TICK))
        else $error("action on a non-tick event");

    // a connect request leaves the policy awaiting the result
    a_connect_awaits: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (res.action == lrbp_pkg::ACT_CONNECT)) |=> st_reg.is_awaiting)
        else $error("connect issued without awaiting");

    // a live connection carries no failure streak
    a_conn_no_failures: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.is_connected |-> (st_reg.failures_total == 16'd0))
        else $error("failures counted while connected");

endmodule
